>>> rtl/ppc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_pkg: shared types, constants and functions of the pose correction core
// Word layouts, command and register codes, CORDIC arctangent table and the
// angle wrap used by the prep stage.
// ----------------------------------------------------------------------------
package ppc_pkg;

    // Iteration count of the rotator, capped by the arctangent table
    localparam int PPC_CORDIC_STAGES = 16;
    localparam int PPC_ATAN_ENTRIES  = 24;
    localparam int PPC_N_CELLS       = (PPC_CORDIC_STAGES < PPC_ATAN_ENTRIES) ?
                                       PPC_CORDIC_STAGES : PPC_ATAN_ENTRIES;
    localparam int PPC_STAGE_W       = 5;

    // Angle units: 1/128 degree
    localparam int PPC_HALF_TURN     = 23040;
    localparam int PPC_FULL_TURN     = 46080;
    localparam int PPC_QUARTER_TURN  = 11520;
    localparam int PPC_ZSHIFT        = 13;

    // Field and datapath widths
    localparam int PPC_POS_W  = 24;
    localparam int PPC_ANG_W  = 16;
    localparam int PPC_OP_W   = 25;
    localparam int PPC_ROT_W  = 33;
    localparam int PPC_Z_W    = 30;
    localparam int PPC_ATAN_W = 26;
    localparam int PPC_PROD_W = 58;
    localparam int PPC_ACC_W  = 61;
    localparam int PPC_FRAC_W = 30;
    localparam int PPC_Q_W    = PPC_ACC_W - PPC_FRAC_W;

    localparam int PPC_INV_GAIN = 652032874;
    localparam int PPC_POS_MAX  = 8388607;
    localparam int PPC_POS_MIN  = -8388608;

    typedef enum logic [1:0] {
        CMD_FORWARD  = 2'd0,
        CMD_BACKWARD = 2'd1,
        CMD_DERIVE   = 2'd2
    } t_ppc_cmd;

    typedef enum logic [1:0] {
        REG_OFFSET_X     = 2'd0,
        REG_OFFSET_Y     = 2'd1,
        REG_OFFSET_ANGLE = 2'd2
    } t_ppc_reg;

    typedef struct packed {
        logic [1:0]                  command;
        logic signed [PPC_POS_W-1:0] pose_x;
        logic signed [PPC_POS_W-1:0] pose_y;
        logic signed [PPC_ANG_W-1:0] pose_angle;
        logic signed [PPC_POS_W-1:0] ref_x;
        logic signed [PPC_POS_W-1:0] ref_y;
        logic signed [PPC_ANG_W-1:0] ref_angle;
    } t_ppc_in;

    typedef struct packed {
        logic signed [PPC_POS_W-1:0] out_x;
        logic signed [PPC_POS_W-1:0] out_y;
        logic signed [PPC_ANG_W-1:0] out_angle;
        logic                        saturated;
    } t_ppc_out;

    typedef struct packed {
        logic signed [PPC_POS_W-1:0] offset_x;
        logic signed [PPC_POS_W-1:0] offset_y;
        logic signed [PPC_ANG_W-1:0] offset_angle;
    } t_ppc_cfg;

    // Operands that ride along the rotator chain
    typedef struct packed {
        logic [1:0]                  cmd;
        logic signed [PPC_OP_W-1:0]  u;
        logic signed [PPC_OP_W-1:0]  v;
        logic signed [PPC_POS_W-1:0] base_x;
        logic signed [PPC_POS_W-1:0] base_y;
        logic signed [PPC_ANG_W-1:0] angle;
        logic                        flip;
    } t_ppc_carry;

    // One rotator cell's content
    typedef struct packed {
        logic                        valid;
        logic signed [PPC_ROT_W-1:0] x;
        logic signed [PPC_ROT_W-1:0] y;
        logic signed [PPC_Z_W-1:0]   z;
        t_ppc_carry                  carry;
    } t_ppc_cell;

    // atan(2^-i) in degrees, 2^20 units per degree
    function automatic logic [PPC_ATAN_W-1:0] ppc_atan(input logic [PPC_STAGE_W-1:0] idx);
        logic [PPC_ATAN_W-1:0] r;
        unique case (idx)
            5'd0:    r = 26'd47185920;
            5'd1:    r = 26'd27855475;
            5'd2:    r = 26'd14718068;
            5'd3:    r = 26'd7471121;
            5'd4:    r = 26'd3750058;
            5'd5:    r = 26'd1876857;
            5'd6:    r = 26'd938658;
            5'd7:    r = 26'd469357;
            5'd8:    r = 26'd234682;
            5'd9:    r = 26'd117342;
            5'd10:   r = 26'd58671;
            5'd11:   r = 26'd29335;
            5'd12:   r = 26'd14668;
            5'd13:   r = 26'd7334;
            5'd14:   r = 26'd3667;
            5'd15:   r = 26'd1833;
            5'd16:   r = 26'd917;
            5'd17:   r = 26'd458;
            5'd18:   r = 26'd229;
            5'd19:   r = 26'd115;
            5'd20:   r = 26'd57;
            5'd21:   r = 26'd29;
            5'd22:   r = 26'd14;
            5'd23:   r = 26'd7;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Wrap into (-180, 180] degrees; one step covers every 17 bit input
    function automatic logic signed [PPC_ANG_W-1:0] ppc_wrap(
        input logic signed [PPC_ANG_W:0] a
    );
        logic signed [PPC_ANG_W+1:0] t;
        t = (PPC_ANG_W+2)'(a);
        if (t <= -PPC_HALF_TURN) begin
            t = (PPC_ANG_W+2)'(t + PPC_FULL_TURN);
        end else if (t > PPC_HALF_TURN) begin
            t = (PPC_ANG_W+2)'(t - PPC_FULL_TURN);
        end
        return t[PPC_ANG_W-1:0];
    endfunction

endpackage

>>> rtl/ppc_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_prep: entry stage
// Forms the result angle, folds the rotation angle into +/-90 degrees and
// picks the multiplier operands and base offset for the command.
// ----------------------------------------------------------------------------
module ppc_prep import ppc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_ppc_in   i_item,
    input  t_ppc_cfg  i_cfg,
    output t_ppc_cell o_cell
);

    logic signed [PPC_ANG_W:0]   raw_angle;
    logic signed [PPC_ANG_W-1:0] res_angle;
    logic signed [PPC_ANG_W-1:0] rot_angle;
    logic signed [PPC_ANG_W-1:0] fold_angle;
    logic                        fold_flip;
    t_ppc_cell                   n_cell;
    t_ppc_cell                   r_cell;

    // Result angle and rotation angle
    always_comb begin
        unique case (i_item.command)
            CMD_FORWARD:  raw_angle = (PPC_ANG_W+1)'(i_item.pose_angle)
                                    - (PPC_ANG_W+1)'(i_cfg.offset_angle);
            CMD_BACKWARD: raw_angle = (PPC_ANG_W+1)'(i_cfg.offset_angle)
                                    + (PPC_ANG_W+1)'(i_item.pose_angle);
            CMD_DERIVE:   raw_angle = (PPC_ANG_W+1)'(i_item.pose_angle)
                                    - (PPC_ANG_W+1)'(i_item.ref_angle);
            default:      raw_angle = '0;
        endcase
        res_angle = ppc_wrap(raw_angle);
        rot_angle = (i_item.command == CMD_DERIVE) ? res_angle
                  : ppc_wrap((PPC_ANG_W+1)'(i_cfg.offset_angle));
    end

    // Fold into +/-90 degrees; the fold negates sine and cosine
    always_comb begin
        if (rot_angle > PPC_QUARTER_TURN) begin
            fold_angle = PPC_ANG_W'(rot_angle - PPC_HALF_TURN);
            fold_flip  = 1'b1;
        end else if (rot_angle < -PPC_QUARTER_TURN) begin
            fold_angle = PPC_ANG_W'(rot_angle + PPC_HALF_TURN);
            fold_flip  = 1'b1;
        end else begin
            fold_angle = rot_angle;
            fold_flip  = 1'b0;
        end
    end

    // Operands and base for the combine stage
    always_comb begin
        n_cell.valid       = i_valid;
        n_cell.x           = PPC_ROT_W'(PPC_INV_GAIN);
        n_cell.y           = '0;
        n_cell.z           = PPC_Z_W'(fold_angle) <<< PPC_ZSHIFT;
        n_cell.carry.cmd   = i_item.command;
        n_cell.carry.angle = res_angle;
        n_cell.carry.flip  = fold_flip;
        unique case (i_item.command)
            CMD_FORWARD: begin
                n_cell.carry.u      = PPC_OP_W'(i_item.pose_x) - PPC_OP_W'(i_cfg.offset_x);
                n_cell.carry.v      = PPC_OP_W'(i_item.pose_y) - PPC_OP_W'(i_cfg.offset_y);
                n_cell.carry.base_x = '0;
                n_cell.carry.base_y = '0;
            end
            CMD_BACKWARD: begin
                n_cell.carry.u      = PPC_OP_W'(i_item.pose_x);
                n_cell.carry.v      = PPC_OP_W'(i_item.pose_y);
                n_cell.carry.base_x = i_cfg.offset_x;
                n_cell.carry.base_y = i_cfg.offset_y;
            end
            CMD_DERIVE: begin
                n_cell.carry.u      = PPC_OP_W'(i_item.ref_x);
                n_cell.carry.v      = PPC_OP_W'(i_item.ref_y);
                n_cell.carry.base_x = i_item.pose_x;
                n_cell.carry.base_y = i_item.pose_y;
            end
            default: begin
                n_cell.carry.u      = '0;
                n_cell.carry.v      = '0;
                n_cell.carry.base_x = '0;
                n_cell.carry.base_y = '0;
            end
        endcase
    end

    // Register the entry word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

>>> rtl/ppc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_cell: one CORDIC rotation step
// Rotates the held vector by +/-atan(2^-k) toward zero residual angle and
// hands the word to the next cell.
// ----------------------------------------------------------------------------
module ppc_cell import ppc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [PPC_STAGE_W-1:0] i_stage,
    input  t_ppc_cell              i_prev,
    output t_ppc_cell              o_next
);

    logic signed [PPC_ROT_W-1:0] x_sh;
    logic signed [PPC_ROT_W-1:0] y_sh;
    logic signed [PPC_Z_W-1:0]   step;
    t_ppc_cell                   n_cell;
    t_ppc_cell                   r_cell;

    // Rotate by the step angle in the sign direction of the residual
    always_comb begin
        x_sh   = i_prev.x >>> i_stage;
        y_sh   = i_prev.y >>> i_stage;
        step   = signed'(PPC_Z_W'(ppc_atan(i_stage)));
        n_cell = i_prev;
        if (!i_prev.z[PPC_Z_W-1]) begin
            n_cell.x = i_prev.x - y_sh;
            n_cell.y = i_prev.y + x_sh;
            n_cell.z = i_prev.z - step;
        end else begin
            n_cell.x = i_prev.x + y_sh;
            n_cell.y = i_prev.y - x_sh;
            n_cell.z = i_prev.z + step;
        end
    end

    // Hand on to the neighbour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_next = r_cell;

endmodule

>>> rtl/ppc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_mac: rotation, accumulate, round and saturate
// Applies the fold sign, forms the four products, adds them to the base at
// 2^30 scale, then rounds half up and clamps to 24 bits.
// ----------------------------------------------------------------------------
module ppc_mac import ppc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_ppc_cell i_cell,
    output logic      o_valid,
    output t_ppc_out  o_item
);

    localparam logic signed [PPC_ACC_W-1:0] HALF_LSB = PPC_ACC_W'(1) <<< (PPC_FRAC_W - 1);

    // Stage A: fold sign applied
    logic                        r_a_valid;
    logic [1:0]                  r_a_cmd;
    logic signed [PPC_OP_W-1:0]  r_a_u, r_a_v;
    logic signed [PPC_POS_W-1:0] r_a_base_x, r_a_base_y;
    logic signed [PPC_ANG_W-1:0] r_a_angle;
    logic signed [PPC_ROT_W-1:0] r_a_c, r_a_s, n_a_c, n_a_s;
    // Stage B: products
    logic                         r_b_valid;
    logic [1:0]                   r_b_cmd;
    logic signed [PPC_POS_W-1:0]  r_b_base_x, r_b_base_y;
    logic signed [PPC_ANG_W-1:0]  r_b_angle;
    logic signed [PPC_PROD_W-1:0] r_b_pc, r_b_ps, r_b_qc, r_b_qs;
    logic signed [PPC_PROD_W-1:0] n_b_pc, n_b_ps, n_b_qc, n_b_qs;
    // Stage C: sums
    logic                        r_c_valid;
    logic [1:0]                  r_c_cmd;
    logic signed [PPC_ANG_W-1:0] r_c_angle;
    logic signed [PPC_ACC_W-1:0] r_c_x, r_c_y, n_c_x, n_c_y;
    logic signed [PPC_ACC_W-1:0] bx, by, pc, ps, qc, qs;
    // Stage D: output word
    logic                        r_d_valid;
    t_ppc_out                    r_d_item, n_d_item;
    logic signed [PPC_ACC_W-1:0] rnd_x, rnd_y;
    logic signed [PPC_Q_W-1:0]   q_x, q_y;
    logic                        sat_x, sat_y;

    // Negate cosine and sine for a folded angle
    always_comb begin
        n_a_c = i_cell.carry.flip ? -i_cell.x : i_cell.x;
        n_a_s = i_cell.carry.flip ? -i_cell.y : i_cell.y;
    end

    // Four products
    always_comb begin
        n_b_pc = r_a_u * r_a_c;
        n_b_ps = r_a_u * r_a_s;
        n_b_qc = r_a_v * r_a_c;
        n_b_qs = r_a_v * r_a_s;
    end

    // Combine products with the base at 2^30 scale
    always_comb begin
        bx = PPC_ACC_W'(r_b_base_x) <<< PPC_FRAC_W;
        by = PPC_ACC_W'(r_b_base_y) <<< PPC_FRAC_W;
        pc = PPC_ACC_W'(r_b_pc);
        ps = PPC_ACC_W'(r_b_ps);
        qc = PPC_ACC_W'(r_b_qc);
        qs = PPC_ACC_W'(r_b_qs);
        unique case (r_b_cmd)
            CMD_FORWARD: begin
                n_c_x = pc + qs;
                n_c_y = qc - ps;
            end
            CMD_BACKWARD: begin
                n_c_x = bx + pc - qs;
                n_c_y = by + qc + ps;
            end
            CMD_DERIVE: begin
                n_c_x = bx - pc + qs;
                n_c_y = by - qc - ps;
            end
            default: begin
                n_c_x = '0;
                n_c_y = '0;
            end
        endcase
    end

    // Round half up, clamp, zero the word for an unused command
    always_comb begin
        rnd_x = r_c_x + HALF_LSB;
        rnd_y = r_c_y + HALF_LSB;
        q_x   = rnd_x[PPC_ACC_W-1:PPC_FRAC_W];
        q_y   = rnd_y[PPC_ACC_W-1:PPC_FRAC_W];
        sat_x = (q_x > PPC_POS_MAX) || (q_x < PPC_POS_MIN);
        sat_y = (q_y > PPC_POS_MAX) || (q_y < PPC_POS_MIN);
        if (q_x > PPC_POS_MAX) begin
            n_d_item.out_x = PPC_POS_W'(PPC_POS_MAX);
        end else if (q_x < PPC_POS_MIN) begin
            n_d_item.out_x = PPC_POS_W'(PPC_POS_MIN);
        end else begin
            n_d_item.out_x = q_x[PPC_POS_W-1:0];
        end
        if (q_y > PPC_POS_MAX) begin
            n_d_item.out_y = PPC_POS_W'(PPC_POS_MAX);
        end else if (q_y < PPC_POS_MIN) begin
            n_d_item.out_y = PPC_POS_W'(PPC_POS_MIN);
        end else begin
            n_d_item.out_y = q_y[PPC_POS_W-1:0];
        end
        n_d_item.out_angle = r_c_angle;
        n_d_item.saturated = sat_x | sat_y;
        if (r_c_cmd != CMD_FORWARD && r_c_cmd != CMD_BACKWARD && r_c_cmd != CMD_DERIVE) begin
            n_d_item = '0;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_cell.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    // Payload, held while the pipe is frozen
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_cmd    <= i_cell.carry.cmd;
            r_a_u      <= i_cell.carry.u;
            r_a_v      <= i_cell.carry.v;
            r_a_base_x <= i_cell.carry.base_x;
            r_a_base_y <= i_cell.carry.base_y;
            r_a_angle  <= i_cell.carry.angle;
            r_a_c      <= n_a_c;
            r_a_s      <= n_a_s;
            r_b_cmd    <= r_a_cmd;
            r_b_base_x <= r_a_base_x;
            r_b_base_y <= r_a_base_y;
            r_b_angle  <= r_a_angle;
            r_b_pc     <= n_b_pc;
            r_b_ps     <= n_b_ps;
            r_b_qc     <= n_b_qc;
            r_b_qs     <= n_b_qs;
            r_c_cmd    <= r_b_cmd;
            r_c_angle  <= r_b_angle;
            r_c_x      <= n_c_x;
            r_c_y      <= n_c_y;
            r_d_item   <= n_d_item;
        end
    end

    assign o_valid = r_d_valid;
    assign o_item  = r_d_item;

    // A saturated word has at least one coordinate on a clamp limit
    a_sat_on_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_valid && r_d_item.saturated) |->
        (r_d_item.out_x == PPC_POS_W'(PPC_POS_MAX) || r_d_item.out_x == PPC_POS_W'(PPC_POS_MIN)
         || r_d_item.out_y == PPC_POS_W'(PPC_POS_MAX)
         || r_d_item.out_y == PPC_POS_W'(PPC_POS_MIN)))
        else $error("saturated flag without a clamped coordinate");

    // Every delivered angle lies in (-180, 180] degrees
    a_angle_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid |-> (r_d_item.out_angle > -PPC_HALF_TURN
                       && r_d_item.out_angle <= PPC_HALF_TURN))
        else $error("output angle not wrapped");

    // A frozen pipe keeps its output word and valid
    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_d_item) && $stable(r_d_valid) && $stable(r_c_x)))
        else $error("pipeline moved while frozen");

endmodule

>>> rtl/planar_pose_correction_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_pose_correction_core: planar pose correction, top level
// Forward, backward and derive transforms with a CORDIC sine/cosine chain.
//
//   Channel   Direction  Handshake            Word
//   pose      in         i_valid / o_stall    i_item (t_ppc_in)
//   result    out        o_valid / i_stall    o_item (t_ppc_out)
//   offsets   in         i_cfg_we             i_cfg_addr, i_cfg_data
//
// One word is taken every cycle while o_stall is low. A word passes one entry
// stage, one cell per CORDIC iteration (16 CORDIC cells), then the sign,
// product, sum and round stages.
// Reset is synchronous: it clears every valid bit and the three offsets.
// The whole pipe freezes only while a finished word waits under i_stall;
// bubbles keep moving otherwise.
// ----------------------------------------------------------------------------
module planar_pose_correction_core import ppc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_ppc_in              i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_ppc_out             o_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_addr,
    input  logic [PPC_POS_W-1:0] i_cfg_data
);

    t_ppc_cfg  r_cfg;
    t_ppc_cell w_chain [0:PPC_N_CELLS];
    logic      w_en;
    logic      w_out_valid;

    // Offset registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_OFFSET_X:     r_cfg.offset_x     <= i_cfg_data;
                REG_OFFSET_Y:     r_cfg.offset_y     <= i_cfg_data;
                REG_OFFSET_ANGLE: r_cfg.offset_angle <= i_cfg_data[PPC_ANG_W-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // Freeze the pipe only while the output word is held
    assign w_en    = !(w_out_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = w_out_valid;

    ppc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_cell  (w_chain[0])
    );

    // CORDIC chain, one iteration per cell
    for (genvar k = 0; k < PPC_N_CELLS; k++) begin : g_cell
        ppc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (PPC_STAGE_W'(k)),
            .i_prev  (w_chain[k]),
            .o_next  (w_chain[k+1])
        );
    end

    ppc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cell  (w_chain[PPC_N_CELLS]),
        .o_valid (w_out_valid),
        .o_item  (o_item)
    );

endmodule
